/* design/kdpc_pkg.sv */
// Shared codes and constants for the key debounce and press classifier.
// No dependencies; imported by every module of the block.
package kdpc_pkg;

   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LONG_PRESS_TICKS = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] DEBOUNCE_TICKS_RESET   = 16'd50;
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd3000;

   localparam logic [1:0] PH_UP        = 2'd0;
   localparam logic [1:0] PH_PRESSING  = 2'd1;
   localparam logic [1:0] PH_DOWN      = 2'd2;
   localparam logic [1:0] PH_RELEASING = 2'd3;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   typedef struct packed {
      logic [1:0] press_event;
      logic [1:0] debounce_phase;
   } result_type;

endpackage

/* design/kdpc_csr.sv */
// Configuration registers: debounce and long-press thresholds.
// Values are clamped to the counter range when written. Uses kdpc_pkg.
module kdpc_csr import kdpc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output logic [COUNT_WIDTH-1:0]    debounce_limit,
   output logic [COUNT_WIDTH-1:0]    long_limit
);

   localparam int LW = (COUNT_WIDTH > CSR_DATA_WIDTH) ? COUNT_WIDTH : CSR_DATA_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   function automatic logic [COUNT_WIDTH-1:0] clamp(input logic [CSR_DATA_WIDTH-1:0] v);
      logic [LW-1:0] wide;
      logic [LW-1:0] top;
      wide = LW'(v);
      top  = LW'(CNT_MAX);
      clamp = (wide > top) ? CNT_MAX : wide[COUNT_WIDTH-1:0];
   endfunction

   logic [COUNT_WIDTH-1:0] debounce_ff, debounce_in;
   logic [COUNT_WIDTH-1:0] long_ff, long_in;

   always_comb begin
      debounce_in = debounce_ff;
      long_in     = long_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_DEBOUNCE_TICKS:   debounce_in = clamp(csr_wdata);
            REG_LONG_PRESS_TICKS: long_in     = clamp(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= clamp(DEBOUNCE_TICKS_RESET);
         long_ff     <= clamp(LONG_PRESS_TICKS_RESET);
      end else begin
         debounce_ff <= debounce_in;
         long_ff     <= long_in;
      end
   end

   assign debounce_limit = debounce_ff;
   assign long_limit     = long_ff;

endmodule

/* design/kdpc_core.sv */
// Debounce phase machine with settle and hold counters, one step per tick.
// Produces the result of the tick combinationally. Uses kdpc_pkg.
module kdpc_core import kdpc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   key_down,
   input  logic [COUNT_WIDTH-1:0] debounce_limit,
   input  logic [COUNT_WIDTH-1:0] long_limit,
   output result_type             result
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] settle_ff, settle_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [1:0]             event_code;

   // phases are evaluated in order, so one tick may pass through several
   always_comb begin
      phase_in   = phase_ff;
      settle_in  = settle_ff;
      hold_in    = hold_ff;
      event_code = EV_NONE;

      if (phase_in == PH_PRESSING || phase_in == PH_RELEASING) begin
         settle_in = sat_inc(settle_in);
      end
      if (phase_in == PH_DOWN || phase_in == PH_RELEASING) begin
         hold_in = sat_inc(hold_in);
      end

      if (phase_in == PH_UP && key_down) begin
         phase_in  = PH_PRESSING;
         settle_in = '0;
      end

      if (phase_in == PH_PRESSING && settle_in >= debounce_limit) begin
         if (key_down) begin
            phase_in = PH_DOWN;
            hold_in  = '0;
         end else begin
            phase_in = PH_UP;
         end
      end

      if (phase_in == PH_DOWN && !key_down) begin
         phase_in  = PH_RELEASING;
         settle_in = '0;
      end

      if (phase_in == PH_RELEASING && settle_in >= debounce_limit) begin
         if (key_down) begin
            phase_in = PH_DOWN;
         end else begin
            phase_in   = PH_UP;
            event_code = (hold_in >= long_limit) ? EV_LONG : EV_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_UP;
         settle_ff <= '0;
         hold_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         settle_ff <= settle_in;
         hold_ff   <= hold_in;
      end
   end

   assign result.press_event    = event_code;
   assign result.debounce_phase = phase_in;

endmodule

/* design/key_debounce_press_classifier.sv */
// Top level of the key debounce and press classifier.
// Instantiates kdpc_csr and kdpc_core; holds the result register. Uses kdpc_pkg.
//
// Usage:
//   req_*  : one raw key sample per tick, key_down in req_tdata[0].
//   rsp_*  : one result per sample: press event and debounce phase after it.
//   csr_*  : write-only threshold registers (debounce, long-press), taken
//            at any edge with csr_we high; write only while no sample is
//            in flight.
// A sample transferred at an edge shows its result on rsp_* right after that
// edge. One sample is taken per cycle while the receiver keeps rsp_tready high,
// set by the combinational phase and counter update between the state registers.
// The result register frees in the same cycle it is taken, so req_tready
// stays high while rsp_tready is high; when the receiver stalls with a
// result pending, req_tready drops until that result is taken.
// Reset puts the machine in the key-up phase with both counters at zero,
// loads the thresholds with 50 and 3000 ticks and empties the result
// register.
module key_debounce_press_classifier import kdpc_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [0] key_down
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // [1:0] press_event, [3:2] debounce_phase
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [COUNT_WIDTH-1:0] debounce_limit;
   logic [COUNT_WIDTH-1:0] long_limit;
   logic                   req_transfer;
   result_type             step_result;
   result_type             result_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_transfer = req_tvalid && req_tready;

   kdpc_csr #(.COUNT_WIDTH(COUNT_WIDTH)) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .debounce_limit (debounce_limit),
      .long_limit     (long_limit)
   );

   kdpc_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (req_transfer),
      .key_down       (req_tdata[0]),
      .debounce_limit (debounce_limit),
      .long_limit     (long_limit),
      .result         (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, result_ff.debounce_phase, result_ff.press_event};

endmodule

/* design/kdpc_checker.sv */
// Port-level checks for key_debounce_press_classifier, attached by bind.
// Uses kdpc_pkg for phase and event codes.
module kdpc_checker import kdpc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_one_per_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("transfer produced no result");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'b0000 && rsp_tdata[1:0] != 2'd3)
      else $error("bad result encoding");

   a_event_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != EV_NONE |-> rsp_tdata[3:2] == PH_UP)
      else $error("press event outside key-up phase");

endmodule

bind key_debounce_press_classifier kdpc_checker u_kdpc_checker (.*);
